// ===== rtl/tll_pkg.sv =====
// Package for the typed lambda lexer: token kinds, character codes,
// scan modes, token record types and character-class helpers.
// No dependencies.
package tll_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int NumberBitsDefault   = 32;
  localparam int QueueDepthDefault   = 4;

  // Token kinds as seen on token_kind
  localparam logic [3:0] KIND_LPAREN = 4'd0;
  localparam logic [3:0] KIND_RPAREN = 4'd1;
  localparam logic [3:0] KIND_DOT    = 4'd2;
  localparam logic [3:0] KIND_COLON  = 4'd3;
  localparam logic [3:0] KIND_NATTY  = 4'd4;
  localparam logic [3:0] KIND_ARROW  = 4'd5;
  localparam logic [3:0] KIND_NUMBER = 4'd6;
  localparam logic [3:0] KIND_LAM    = 4'd7;
  localparam logic [3:0] KIND_REC    = 4'd8;
  localparam logic [3:0] KIND_VAR    = 4'd9;
  localparam logic [3:0] KIND_EOF    = 4'd10;
  localparam logic [3:0] KIND_ERROR  = 4'd11;

  localparam logic [7:0] CHAR_LPAREN     = 8'h28;
  localparam logic [7:0] CHAR_RPAREN     = 8'h29;
  localparam logic [7:0] CHAR_DOT        = 8'h2e;
  localparam logic [7:0] CHAR_COLON      = 8'h3a;
  localparam logic [7:0] CHAR_NAT        = 8'h4e;
  localparam logic [7:0] CHAR_DASH       = 8'h2d;
  localparam logic [7:0] CHAR_GT         = 8'h3e;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

  localparam logic [23:0] KEYWORD_LAM = 24'h6c616d;
  localparam logic [23:0] KEYWORD_REC = 24'h726563;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_NUM   = 5'b00010,
    MODE_IDENT = 5'b00100,
    MODE_DASH  = 5'b01000,
    MODE_ERR   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [31:0] value;
    logic        saturated;
  } token_t;

  // Up to two tokens caused by one input word
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } token_pair_t;

  function automatic token_t make_token(logic [3:0] kind, logic [15:0] start,
                                        logic [15:0] length, logic [31:0] value,
                                        logic saturated);
    token_t t;
    t.kind      = kind;
    t.start     = start;
    t.length    = length;
    t.value     = value;
    t.saturated = saturated;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

endpackage

// ===== rtl/tll_front.sv =====
// Scanner front end: takes one text word per cycle while take is high, tracks the
// pending token and produces up to two finished tokens per word.
// Depends on tll_pkg.
module tll_front #(
  parameter int POSITION_BITS = tll_pkg::PositionBitsDefault,
  parameter int NUMBER_BITS   = tll_pkg::NumberBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 pair_valid,
  output tll_pkg::token_pair_t pair
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [NUMBER_BITS-1:0]   NumMax = '1;

  tll_pkg::mode_t           mode, mode_next;
  logic [POSITION_BITS-1:0] text_position, text_position_next;
  logic [POSITION_BITS-1:0] pending_start, pending_start_next;
  logic [POSITION_BITS-1:0] pending_length, pending_length_next;
  logic [NUMBER_BITS-1:0]   number_accumulator, number_accumulator_next;
  logic                     overflow_seen, overflow_seen_next;
  logic [23:0]              identifier_prefix, identifier_prefix_next;

  logic [POSITION_BITS-1:0] pos_inc, len_inc;
  logic [POSITION_BITS+15:0] pos_ext, start_ext, len_ext;
  logic [NUMBER_BITS+31:0]  value_ext;
  logic [15:0]              pos16, start16, len16;
  logic [31:0]              value32;
  logic [NUMBER_BITS+3:0]   mac;
  logic [3:0]               ident_kind;
  tll_pkg::token_t          tok_a, tok_b;
  logic                     a_valid, b_valid, consumed;

  assign pos_inc = (text_position == PosMax) ? text_position : text_position + 1'b1;
  assign len_inc = (pending_length == PosMax) ? pending_length : pending_length + 1'b1;

  // Truncate or zero-extend state to the fixed output widths
  assign pos_ext   = {16'b0, text_position};
  assign start_ext = {16'b0, pending_start};
  assign len_ext   = {16'b0, pending_length};
  assign value_ext = {32'b0, number_accumulator};
  assign pos16     = pos_ext[15:0];
  assign start16   = start_ext[15:0];
  assign len16     = len_ext[15:0];
  assign value32   = value_ext[31:0];

  // acc*10 + digit; any carry into the top bits means saturation
  assign mac = ({4'b0, number_accumulator} << 3) + ({4'b0, number_accumulator} << 1)
             + (NUMBER_BITS+4)'(text_byte[3:0]);

  always_comb begin
    ident_kind = tll_pkg::KIND_VAR;
    if (pending_length == POSITION_BITS'(3)) begin
      if (identifier_prefix == tll_pkg::KEYWORD_LAM) ident_kind = tll_pkg::KIND_LAM;
      else if (identifier_prefix == tll_pkg::KEYWORD_REC) ident_kind = tll_pkg::KIND_REC;
    end
  end

  always_comb begin
    mode_next               = mode;
    text_position_next      = text_position;
    pending_start_next      = pending_start;
    pending_length_next     = pending_length;
    number_accumulator_next = number_accumulator;
    overflow_seen_next      = overflow_seen;
    identifier_prefix_next  = identifier_prefix;
    tok_a    = '0;
    tok_b    = '0;
    a_valid  = 1'b0;
    b_valid  = 1'b0;
    consumed = 1'b0;

    if (end_of_text) begin
      // Flush the pending token, close the text, restart
      unique case (mode)
        tll_pkg::MODE_NUM: begin
          a_valid = 1'b1;
          tok_a = tll_pkg::make_token(tll_pkg::KIND_NUMBER, start16, len16, value32,
                                      overflow_seen);
        end
        tll_pkg::MODE_IDENT: begin
          a_valid = 1'b1;
          tok_a = tll_pkg::make_token(ident_kind, start16, len16, '0, 1'b0);
        end
        tll_pkg::MODE_DASH: begin
          a_valid = 1'b1;
          tok_a = tll_pkg::make_token(tll_pkg::KIND_ERROR, start16, 16'd1, '0, 1'b0);
        end
        default: ;
      endcase
      b_valid = 1'b1;
      tok_b = tll_pkg::make_token(tll_pkg::KIND_EOF, pos16, 16'd0, '0, 1'b0);
      mode_next               = tll_pkg::MODE_IDLE;
      text_position_next      = '0;
      pending_start_next      = '0;
      pending_length_next     = '0;
      number_accumulator_next = '0;
      overflow_seen_next      = 1'b0;
      identifier_prefix_next  = '0;
    end else begin
      unique case (mode)
        tll_pkg::MODE_ERR: consumed = 1'b1;
        tll_pkg::MODE_NUM: begin
          if (tll_pkg::is_digit(text_byte)) begin
            consumed = 1'b1;
            pending_length_next = len_inc;
            if (mac[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
              number_accumulator_next = NumMax;
              overflow_seen_next      = 1'b1;
            end else begin
              number_accumulator_next = mac[NUMBER_BITS-1:0];
            end
          end else begin
            a_valid = 1'b1;
            tok_a = tll_pkg::make_token(tll_pkg::KIND_NUMBER, start16, len16, value32,
                                        overflow_seen);
            mode_next = tll_pkg::MODE_IDLE;
          end
        end
        tll_pkg::MODE_IDENT: begin
          if (tll_pkg::is_letter(text_byte) || tll_pkg::is_digit(text_byte) ||
              (text_byte == tll_pkg::CHAR_UNDERSCORE)) begin
            consumed = 1'b1;
            if (pending_length < POSITION_BITS'(3))
              identifier_prefix_next = {identifier_prefix[15:0], text_byte};
            pending_length_next = len_inc;
          end else begin
            a_valid = 1'b1;
            tok_a = tll_pkg::make_token(ident_kind, start16, len16, '0, 1'b0);
            mode_next = tll_pkg::MODE_IDLE;
          end
        end
        tll_pkg::MODE_DASH: begin
          consumed = 1'b1;
          a_valid  = 1'b1;
          if (text_byte == tll_pkg::CHAR_GT) begin
            tok_a = tll_pkg::make_token(tll_pkg::KIND_ARROW, start16, 16'd2, '0, 1'b0);
            mode_next = tll_pkg::MODE_IDLE;
          end else begin
            tok_a = tll_pkg::make_token(tll_pkg::KIND_ERROR, start16, 16'd1, '0, 1'b0);
            mode_next = tll_pkg::MODE_ERR;
          end
        end
        default: ;
      endcase

      if (!consumed) begin
        if (tll_pkg::is_space(text_byte)) begin
          b_valid = 1'b0;
        end else if (text_byte == tll_pkg::CHAR_LPAREN) begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_LPAREN, pos16, 16'd1, '0, 1'b0);
        end else if (text_byte == tll_pkg::CHAR_RPAREN) begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_RPAREN, pos16, 16'd1, '0, 1'b0);
        end else if (text_byte == tll_pkg::CHAR_DOT) begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_DOT, pos16, 16'd1, '0, 1'b0);
        end else if (text_byte == tll_pkg::CHAR_COLON) begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_COLON, pos16, 16'd1, '0, 1'b0);
        end else if (text_byte == tll_pkg::CHAR_NAT) begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_NATTY, pos16, 16'd1, '0, 1'b0);
        end else if (text_byte == tll_pkg::CHAR_DASH) begin
          mode_next          = tll_pkg::MODE_DASH;
          pending_start_next = text_position;
        end else if (tll_pkg::is_digit(text_byte)) begin
          mode_next               = tll_pkg::MODE_NUM;
          pending_start_next      = text_position;
          pending_length_next     = POSITION_BITS'(1);
          number_accumulator_next = NUMBER_BITS'(text_byte[3:0]);
          overflow_seen_next      = 1'b0;
        end else if (tll_pkg::is_letter(text_byte)) begin
          mode_next              = tll_pkg::MODE_IDENT;
          pending_start_next     = text_position;
          pending_length_next    = POSITION_BITS'(1);
          identifier_prefix_next = {16'b0, text_byte};
        end else begin
          b_valid = 1'b1;
          tok_b = tll_pkg::make_token(tll_pkg::KIND_ERROR, pos16, 16'd1, '0, 1'b0);
          mode_next = tll_pkg::MODE_ERR;
        end
      end
      text_position_next = pos_inc;
    end
  end

  // Compact: a lone token always travels in the first slot
  assign pair_valid  = take && (a_valid || b_valid);
  assign pair.first  = a_valid ? tok_a : tok_b;
  assign pair.second = tok_b;
  assign pair.two    = a_valid && b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= tll_pkg::MODE_IDLE;
      text_position      <= '0;
      pending_start      <= '0;
      pending_length     <= '0;
      number_accumulator <= '0;
      overflow_seen      <= 1'b0;
      identifier_prefix  <= '0;
    end else if (take) begin
      mode               <= mode_next;
      text_position      <= text_position_next;
      pending_start      <= pending_start_next;
      pending_length     <= pending_length_next;
      number_accumulator <= number_accumulator_next;
      overflow_seen      <= overflow_seen_next;
      identifier_prefix  <= identifier_prefix_next;
    end
  end

endmodule

// ===== rtl/tll_queue.sv =====
// Short queue of token pairs between the scanner and the token sequencer.
// Depends on tll_pkg.
module tll_queue #(
  parameter int DEPTH = tll_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tll_pkg::token_pair_t push_data,
  output logic                 full,
  input  logic                 pop,
  output tll_pkg::token_pair_t head,
  output logic                 empty
);

  localparam int IndexBits = $clog2(DEPTH);
  localparam int CountBits = $clog2(DEPTH + 1);

  tll_pkg::token_pair_t entries [DEPTH];
  logic [IndexBits-1:0] wr_ptr, rd_ptr;
  logic [CountBits-1:0] count;
  logic                 do_push, do_pop;

  assign full    = (count == CountBits'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == IndexBits'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == IndexBits'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/tll_back.sv =====
// Token sequencer: hands out the tokens of the head pair one token at a time
// and retires the pair after its last token. Depends on tll_pkg.
module tll_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tll_pkg::token_pair_t head,
  input  logic                 queue_empty,
  input  logic                 pop,
  output logic                 queue_pop,
  output logic [3:0]           token_kind,
  output logic [15:0]          token_start,
  output logic [15:0]          token_length,
  output logic [31:0]          number_value,
  output logic                 number_saturated,
  output logic                 last_result
);

  logic            second_half;
  tll_pkg::token_t current;
  logic            taken;

  assign current          = second_half ? head.second : head.first;
  assign last_result      = second_half || !head.two;
  assign taken            = pop && !queue_empty;
  assign queue_pop        = taken && last_result;
  assign token_kind       = current.kind;
  assign token_start      = current.start;
  assign token_length     = current.length;
  assign number_value     = current.value;
  assign number_saturated = current.saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_half <= 1'b0;
    end else if (taken) begin
      // advance to the second token, or drop back for the next pair
      second_half <= !last_result;
    end
  end

endmodule

// ===== rtl/typed_lambda_lexer.sv =====
// Streaming lexer for a small typed lambda language, top level.
// Depends on tll_pkg, tll_front, tll_queue and tll_back.
//
// Usage:
//   Input channel: drive text_byte / end_of_text and raise push; a word is
//   taken at a rising edge with push high and full low. One text byte per
//   word; end_of_text flushes the pending token, emits end-of-file and
//   restarts position counting for the next text.
//   Result channel: while empty is low, the oldest token sits on token_kind,
//   token_start, token_length, number_value, number_saturated and
//   last_result; raise pop to take it. last_result marks the final token
//   caused by one input word (each word causes zero, one or two tokens).
//   A token is queued as its word is taken; it shows after those ahead of it.
//   Throughput: one input word per cycle while full is low; the scanner
//   updates its state with a single shift-add multiply-accumulate per byte.
//   The queue between scanner and sequencer holds QUEUE_DEPTH token pairs;
//   when the receiver stalls it fills and full rises, holding the sender.
//   Two-token words drain at one token per cycle, set by the result port.
//   Reset (rst, synchronous) empties the queue and returns the scanner to
//   idle at text position zero.
module typed_lambda_lexer #(
  parameter int POSITION_BITS = tll_pkg::PositionBitsDefault,
  parameter int NUMBER_BITS   = tll_pkg::NumberBitsDefault,
  parameter int QUEUE_DEPTH   = tll_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [31:0] number_value,
  output logic        number_saturated,
  output logic        last_result
);

  logic                 take;
  logic                 pair_valid;
  tll_pkg::token_pair_t pair;
  tll_pkg::token_pair_t head;
  logic                 queue_pop;

  // Scanner advances on every accepted word
  assign take = push && !full;

  tll_front #(
    .POSITION_BITS(POSITION_BITS),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  // Words that make no token never enter the queue
  tll_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (pair_valid),
    .push_data(pair),
    .full     (full),
    .pop      (queue_pop),
    .head     (head),
    .empty    (empty)
  );

  tll_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .queue_empty     (empty),
    .pop             (pop),
    .queue_pop       (queue_pop),
    .token_kind      (token_kind),
    .token_start     (token_start),
    .token_length    (token_length),
    .number_value    (number_value),
    .number_saturated(number_saturated),
    .last_result     (last_result)
  );

endmodule

// ===== verif/tb_typed_lambda_lexer.sv =====
`timescale 1ns / 100ps
// Self-checking bench for typed_lambda_lexer: a directed table, one long identifier
// and random texts. Depends on tll_pkg and the lexer RTL only.
module tb_typed_lambda_lexer;

  localparam int HOLD_CYCLES = 200;
  localparam int LONG_TEXT   = 40;
  localparam int WORDS_PER_PHASE = 80;

  // One input word: a text byte or an end-of-text mark. A pinned word carries
  // the single token it must produce, typed in by hand.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic        pinned;
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } text_word_t;

  typedef struct {
    tll_pkg::token_t tok;
    logic            last;
  } due_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [31:0] number_value;
  logic        number_saturated;
  logic        last_result;

  text_word_t      offered = '0;
  text_word_t      plan[$];
  text_word_t      probes[28];
  due_t            due_tokens[$];
  tll_pkg::token_t fresh_toks[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int words_sent = 0;
  int tokens_checked = 0;
  int mismatches = 0;
  int full_cycles = 0;
  int phase_words;

  // Scanner state of the predictor
  tll_pkg::mode_t scan_state;
  logic [15:0]    cursor;
  logic [15:0]    tok_start;
  logic [15:0]    tok_len;
  logic [31:0]    accum;
  logic           accum_sat;
  logic [23:0]    head_chars;

  typed_lambda_lexer DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .empty(empty),
    .pop(pop),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .number_value(number_value),
    .number_saturated(number_saturated),
    .last_result(last_result)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  // Positions and lengths stick at the top instead of wrapping
  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void restart_scan();
    scan_state = tll_pkg::MODE_IDLE;
    cursor     = '0;
    tok_start  = '0;
    tok_len    = '0;
    accum      = '0;
    accum_sat  = 1'b0;
    head_chars = '0;
  endfunction

  // Fold one decimal digit in, clamping at the 32-bit maximum
  function automatic void fold_digit(logic [7:0] c);
    longint unsigned d;
    longint unsigned top;
    d   = c - "0";
    top = 64'hFFFF_FFFF;
    if (accum > (top - d) / 10) begin
      accum     = 32'hFFFF_FFFF;
      accum_sat = 1'b1;
    end else begin
      accum = 32'(accum * 10 + d);
    end
  endfunction

  function automatic void add_tok(logic [3:0] kind, logic [15:0] start, logic [15:0] len,
                                  logic [31:0] value, logic sat);
    fresh_toks.push_back(tll_pkg::token_t'{kind, start, len, value, sat});
  endfunction

  // Close whatever token is still open: number, identifier or lone dash
  function automatic void close_pending();
    logic [3:0] kind;
    case (scan_state)
      tll_pkg::MODE_NUM:
        add_tok(tll_pkg::KIND_NUMBER, tok_start, tok_len, accum, accum_sat);
      tll_pkg::MODE_IDENT: begin
        kind = tll_pkg::KIND_VAR;
        if (tok_len == 16'd3 && head_chars == tll_pkg::KEYWORD_LAM) kind = tll_pkg::KIND_LAM;
        if (tok_len == 16'd3 && head_chars == tll_pkg::KEYWORD_REC) kind = tll_pkg::KIND_REC;
        add_tok(kind, tok_start, tok_len, 32'd0, 1'b0);
      end
      tll_pkg::MODE_DASH: add_tok(tll_pkg::KIND_ERROR, tok_start, 16'd1, 32'd0, 1'b0);
      default: ;
    endcase
  endfunction

  // Work out the tokens one accepted word produces, into fresh_toks
  function automatic void lex_word(logic [7:0] c, logic eot);
    logic taken;
    fresh_toks.delete();
    taken = 1'b0;
    if (eot) begin
      close_pending();
      add_tok(tll_pkg::KIND_EOF, cursor, 16'd0, 32'd0, 1'b0);
      restart_scan();
      return;
    end
    if (scan_state == tll_pkg::MODE_ERR) begin
      cursor = bump(cursor);
      return;
    end
    case (scan_state)
      tll_pkg::MODE_NUM:
        if (digit_char(c)) begin
          fold_digit(c);
          tok_len = bump(tok_len);
          taken = 1'b1;
        end else begin
          close_pending();
          scan_state = tll_pkg::MODE_IDLE;
        end
      tll_pkg::MODE_IDENT:
        if (alpha_char(c) || digit_char(c) || c == tll_pkg::CHAR_UNDERSCORE) begin
          if (tok_len < 16'd3) head_chars = {head_chars[15:0], c};
          tok_len = bump(tok_len);
          taken = 1'b1;
        end else begin
          close_pending();
          scan_state = tll_pkg::MODE_IDLE;
        end
      tll_pkg::MODE_DASH: begin
        if (c == tll_pkg::CHAR_GT) begin
          add_tok(tll_pkg::KIND_ARROW, tok_start, 16'd2, 32'd0, 1'b0);
          scan_state = tll_pkg::MODE_IDLE;
        end else begin
          // the byte after a lone dash is swallowed along with the error
          add_tok(tll_pkg::KIND_ERROR, tok_start, 16'd1, 32'd0, 1'b0);
          scan_state = tll_pkg::MODE_ERR;
        end
        taken = 1'b1;
      end
      default: ;
    endcase
    if (!taken) begin
      if (blank_char(c)) begin
      end else if (c == tll_pkg::CHAR_LPAREN) begin
        add_tok(tll_pkg::KIND_LPAREN, cursor, 16'd1, 32'd0, 1'b0);
      end else if (c == tll_pkg::CHAR_RPAREN) begin
        add_tok(tll_pkg::KIND_RPAREN, cursor, 16'd1, 32'd0, 1'b0);
      end else if (c == tll_pkg::CHAR_DOT) begin
        add_tok(tll_pkg::KIND_DOT, cursor, 16'd1, 32'd0, 1'b0);
      end else if (c == tll_pkg::CHAR_COLON) begin
        add_tok(tll_pkg::KIND_COLON, cursor, 16'd1, 32'd0, 1'b0);
      end else if (c == tll_pkg::CHAR_NAT) begin
        add_tok(tll_pkg::KIND_NATTY, cursor, 16'd1, 32'd0, 1'b0);
      end else if (c == tll_pkg::CHAR_DASH) begin
        scan_state = tll_pkg::MODE_DASH;
        tok_start  = cursor;
      end else if (digit_char(c)) begin
        scan_state = tll_pkg::MODE_NUM;
        tok_start  = cursor;
        tok_len    = 16'd1;
        accum      = '0;
        accum_sat  = 1'b0;
        fold_digit(c);
      end else if (alpha_char(c)) begin
        scan_state = tll_pkg::MODE_IDENT;
        tok_start  = cursor;
        tok_len    = 16'd1;
        head_chars = {16'd0, c};
      end else begin
        add_tok(tll_pkg::KIND_ERROR, cursor, 16'd1, 32'd0, 1'b0);
        scan_state = tll_pkg::MODE_ERR;
      end
    end
    cursor = bump(cursor);
  endfunction

  // ---------------------------------------------------------------- checking

  // Queue the expected tokens of the word taken at this edge. A pinned word
  // still runs through the predictor to keep its state in step.
  function automatic void record_word();
    due_t d;
    words_sent++;
    lex_word(text_byte, end_of_text);
    if (offered.pinned) begin
      d.tok  = tll_pkg::token_t'{offered.kind, offered.start, offered.len, 32'd0, 1'b0};
      d.last = 1'b1;
      due_tokens.push_back(d);
    end else begin
      foreach (fresh_toks[i]) begin
        d.tok  = fresh_toks[i];
        d.last = (i == fresh_toks.size() - 1);
        due_tokens.push_back(d);
      end
    end
  endfunction

  function automatic void check_token();
    due_t            want;
    tll_pkg::token_t got;
    got = tll_pkg::token_t'{token_kind, token_start, token_length, number_value,
                            number_saturated};
    tokens_checked++;
    if (due_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: token kind %0d start %0d came with nothing expected",
                 $time, got.kind, got.start);
      return;
    end
    want = due_tokens.pop_front();
    if (got !== want.tok || last_result !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: token mismatch", $time);
        $display("  expected kind %0d start %0d len %0d value %0d sat %b last %b",
                 want.tok.kind, want.tok.start, want.tok.length, want.tok.value,
                 want.tok.saturated, want.last);
        $display("  actual   kind %0d start %0d len %0d value %0d sat %b last %b",
                 got.kind, got.start, got.length, got.value, got.saturated, last_result);
      end
    end
  endfunction

  // Sample both handshakes at the edge; outputs still hold pre-edge values here
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_token();
      if (push && !full) record_word();
      if (push && full) full_cycles++;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a new ticket shows up
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      pop         <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic plan_char(input logic [7:0] c);
    plan.push_back(text_word_t'{c, 1'b0, 1'b0, 4'd0, 16'd0, 16'd0});
    phase_words++;
  endtask

  // Close the text; the byte lane carries junk that must be ignored
  task automatic plan_end();
    plan.push_back(text_word_t'{8'($urandom_range(0, 255)), 1'b1, 1'b0, 4'd0, 16'd0, 16'd0});
    phase_words++;
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    if (r < 62) return 8'("0" + (r - 52));
    return tll_pkg::CHAR_UNDERSCORE;
  endfunction

  function automatic logic [7:0] blank_pick();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'd32 : 8'(r);
  endfunction

  task automatic plan_digits(input string s);
    foreach (s[i]) plan_char(s[i]);
  endtask

  // One random text: mostly well-formed lexemes, some noise and broken arrows
  task automatic plan_text();
    int pick;
    int n;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        case ($urandom_range(0, 4))
          0: plan_char(tll_pkg::CHAR_LPAREN);
          1: plan_char(tll_pkg::CHAR_RPAREN);
          2: plan_char(tll_pkg::CHAR_DOT);
          3: plan_char(tll_pkg::CHAR_COLON);
          default: plan_char(tll_pkg::CHAR_NAT);
        endcase
      end else if (pick < 22) begin
        plan_char(tll_pkg::CHAR_DASH);
        plan_char(tll_pkg::CHAR_GT);
      end else if (pick < 42) begin
        case ($urandom_range(0, 9))
          0: plan_digits("4294967295");
          1: plan_digits("4294967296");
          2: n = 20;
          default: n = $urandom_range(1, 12);
        endcase
        if (n != 0) repeat (n) plan_char(8'("0" + $urandom_range(0, 9)));
        n = 0;
      end else if (pick < 68) begin
        plan_char(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                          : "A" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 7)) plan_char(ident_char());
      end else if (pick < 78) begin
        case ($urandom_range(0, 4))
          0: plan_digits("lam");
          1: plan_digits("rec");
          2: plan_digits("la");
          3: plan_digits("lamb");
          default: plan_digits("Rec");
        endcase
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) plan_char(blank_pick());
      end else if (pick < 94) begin
        plan_char(8'($urandom_range(0, 255)));
      end else begin
        // lone dash: followed by a stray byte, or left hanging at end of text
        plan_char(tll_pkg::CHAR_DASH);
        if ($urandom_range(0, 1)) plan_char(8'("a" + $urandom_range(0, 25)));
      end
      if ($urandom_range(0, 1)) plan_char(blank_pick());
    end
    plan_end();
  endtask

  // Offer each planned word and hold it until the block takes it
  task automatic send_plan();
    text_word_t w;
    while (plan.size() != 0) begin
      w = plan.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push        <= 1'b1;
      text_byte   <= w.ch;
      end_of_text <= w.eot;
      offered     <= w;
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_words    = 0;
    while (phase_words < WORDS_PER_PHASE) plan_text();
    send_plan();
  endtask

  initial begin
    restart_scan();
    // Directed table. Pinned rows give the token by hand; the rest go through
    // the predictor (keywords, two tokens from one word, dash at end of text).
    probes = '{
      '{tll_pkg::CHAR_LPAREN, 1'b0, 1'b1, tll_pkg::KIND_LPAREN, 16'd0, 16'd1},
      '{tll_pkg::CHAR_NAT,    1'b0, 1'b1, tll_pkg::KIND_NATTY,  16'd1, 16'd1},
      '{tll_pkg::CHAR_DASH,   1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_GT,     1'b0, 1'b1, tll_pkg::KIND_ARROW,  16'd2, 16'd2},
      '{"l",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"a",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"m",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_DOT,    1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"r",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"e",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"c",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_COLON,  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"Z",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_UNDERSCORE, 1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"z",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_RPAREN, 1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{tll_pkg::CHAR_DASH,   1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{8'hA5,                1'b1, 1'b0, 4'd0, 16'd0, 16'd0},
      '{8'hFF,                1'b0, 1'b1, tll_pkg::KIND_ERROR,  16'd0, 16'd1},
      '{tll_pkg::CHAR_LPAREN, 1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{8'h00,                1'b1, 1'b1, tll_pkg::KIND_EOF,    16'd2, 16'd0},
      '{8'h00,                1'b0, 1'b1, tll_pkg::KIND_ERROR,  16'd0, 16'd1},
      '{8'hFF,                1'b1, 1'b1, tll_pkg::KIND_EOF,    16'd1, 16'd0},
      '{tll_pkg::CHAR_DASH,   1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{"x",                  1'b0, 1'b1, tll_pkg::KIND_ERROR,  16'd0, 16'd1},
      '{8'h5A,                1'b1, 1'b1, tll_pkg::KIND_EOF,    16'd2, 16'd0},
      '{"7",                  1'b0, 1'b0, 4'd0, 16'd0, 16'd0},
      '{8'h00,                1'b1, 1'b0, 4'd0, 16'd0, 16'd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table with no idling on either side
    foreach (probes[i]) plan.push_back(probes[i]);
    send_plan();

    // One long identifier, well past the keyword prefix, then a paren and
    // end of text
    plan_char("q");
    repeat (LONG_TEXT - 1) plan_char(ident_char());
    plan_char(tll_pkg::CHAR_RPAREN);
    plan_end();
    send_plan();

    // Random texts under each idling mix; park the receiver first so the
    // queue fills and full pushes back on the sender
    hold_ticket <= hold_ticket + 1;
    random_phase(0, 0);
    random_phase(60, 0);
    random_phase(0, 60);
    random_phase(24, 24);

    // Drain, then give a stray late token time to show up
    recv_stall_pct = 0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d words and %0d tokens: directed table, a %0d-byte text,",
             words_sent, tokens_checked, LONG_TEXT + 2);
    $display("random texts under four idling mixes, %0d cycles with full holding input",
             full_cycles);
    if (mismatches == 0 && due_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a healthy run needs well under a tenth of this
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tll_pkg.sv
rtl/tll_front.sv
rtl/tll_queue.sv
rtl/tll_back.sv
rtl/typed_lambda_lexer.sv
verif/tb_typed_lambda_lexer.sv
